// ===== hdl/swhc_pkg.sv =====
// Package with the constants, codes and types of the sliding window hit counter.
`default_nettype none
package swhc_pkg;

  localparam int WINDOW_SECONDS = 300;
  localparam int STAMP_W = 31;
  localparam int COUNT_W = 32;
  localparam int TOTAL_W = 41;
  localparam int IDX_W = $clog2(WINDOW_SECONDS);
  localparam int ENTRY_W = STAMP_W + COUNT_W;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(WINDOW_SECONDS - 1);
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
  localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

  localparam logic REQ_HIT = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MOD,
    ST_HRD,
    ST_HWR,
    ST_QRUN,
    ST_QLAST,
    ST_QOUT
  } state_t;

endpackage
`default_nettype wire

// ===== hdl/swhc_req_if.sv =====
// Request channel of the sliding window hit counter.
`default_nettype none
interface swhc_req_if;
  logic valid;
  logic ready;
  logic req_type;
  logic [30:0] timestamp;

  modport source (output valid, output req_type, output timestamp, input ready);
  modport sink (input valid, input req_type, input timestamp, output ready);
endinterface
`default_nettype wire

// ===== hdl/swhc_res_if.sv =====
// Result channel of the sliding window hit counter.
`default_nettype none
interface swhc_res_if;
  logic valid;
  logic ready;
  logic [40:0] hit_total;

  modport source (output valid, output hit_total, input ready);
  modport sink (input valid, input hit_total, output ready);
endinterface
`default_nettype wire

// ===== hdl/swhc_ram.sv =====
// Generic single write port RAM with one registered read port.
`default_nettype none
module swhc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== hdl/swhc_mod.sv =====
// Unit that reduces a timestamp modulo the window length by reciprocal multiplication.
`default_nettype none
module swhc_mod
  import swhc_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire logic [STAMP_W-1:0] value,
  output logic                    done,
  output logic      [IDX_W-1:0]   rem
);

  localparam int SHIFT = STAMP_W + IDX_W;
  localparam int PROD_W = 2 * STAMP_W + 1;
  localparam logic [STAMP_W:0] RECIP =
    (STAMP_W + 1)'(((64'd1 << SHIFT) + 64'(WINDOW_SECONDS) - 64'd1) / 64'(WINDOW_SECONDS));
  localparam logic [STAMP_W-1:0] MODULUS = STAMP_W'(WINDOW_SECONDS);

  logic mul_vld;
  logic sub_vld;
  logic [STAMP_W-1:0] val;
  logic [STAMP_W-1:0] quo;
  logic [PROD_W-1:0] prod;
  logic [STAMP_W-1:0] back;

  always_comb begin
    prod = PROD_W'(val) * PROD_W'(RECIP);
    back = STAMP_W'(quo * MODULUS);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mul_vld <= 1'b0;
      sub_vld <= 1'b0;
      done <= 1'b0;
    end else begin
      mul_vld <= start;
      sub_vld <= mul_vld;
      done <= sub_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      val <= value;
    end
    if (mul_vld) begin
      quo <= STAMP_W'(prod >> SHIFT);
    end
    if (sub_vld) begin
      rem <= IDX_W'(val - back);
    end
  end

endmodule
`default_nettype wire

// ===== hdl/sliding_window_hit_counter.sv =====
// Top level of the sliding window hit counter: sequencer, bucket store and window sum.
// A hit request is accepted, reduced modulo the window length in the modulo unit, then its bucket is read and written.
// A query request reads all 300 buckets, one per cycle, and sums the counts of those within the window.
// One request is in work at a time; a query waits while the output register is still full.
// After reset the bucket RAM is cleared one entry per cycle, all 300 entries, before
// the first request is accepted.
`default_nettype none
module sliding_window_hit_counter
  import swhc_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  swhc_req_if.sink    req,
  swhc_res_if.source  res
);

  state_t state, state_next;
  logic [IDX_W-1:0] cnt, cnt_next;
  logic [STAMP_W-1:0] req_time;
  logic [TOTAL_W-1:0] total;
  logic rd_vld;

  logic accept;
  logic mod_start, mod_done;
  logic [IDX_W-1:0] mod_rem;

  logic ram_we;
  logic [IDX_W-1:0] ram_waddr, ram_raddr;
  logic [ENTRY_W-1:0] ram_wdata, ram_rdata;

  logic [STAMP_W-1:0] rd_stamp;
  logic [COUNT_W-1:0] rd_count;
  logic [COUNT_W-1:0] hit_count;
  logic signed [STAMP_W:0] diff;
  logic in_window;
  logic [TOTAL_W:0] sum;
  logic [TOTAL_W-1:0] total_add;

  assign accept = req.valid && req.ready;
  assign mod_start = accept && (req.req_type == REQ_HIT);
  assign rd_stamp = ram_rdata[ENTRY_W-1:COUNT_W];
  assign rd_count = ram_rdata[COUNT_W-1:0];

  swhc_mod u_mod (
    .clk   (clk),
    .rst   (rst),
    .start (mod_start),
    .value (req.timestamp),
    .done  (mod_done),
    .rem   (mod_rem)
  );

  swhc_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (WINDOW_SECONDS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    if (rd_stamp != req_time) begin
      hit_count = COUNT_W'(1);
    end else if (rd_count == COUNT_MAX) begin
      hit_count = rd_count;
    end else begin
      hit_count = rd_count + 1'b1;
    end
    diff = $signed({1'b0, req_time}) - $signed({1'b0, rd_stamp});
    in_window = diff < $signed((STAMP_W + 1)'(WINDOW_SECONDS));
    sum = {1'b0, total} + (TOTAL_W + 1)'(rd_count);
    total_add = sum[TOTAL_W] ? TOTAL_MAX : sum[TOTAL_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      cnt <= '0;
      rd_vld <= 1'b0;
      res.valid <= 1'b0;
    end else begin
      state <= state_next;
      cnt <= cnt_next;
      rd_vld <= (state == ST_QRUN);
      if (state == ST_QOUT && (!res.valid || res.ready)) begin
        res.valid <= 1'b1;
      end else if (res.ready) begin
        res.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_time <= req.timestamp;
      total <= '0;
    end else if (rd_vld && in_window) begin
      total <= total_add;
    end
    if (state == ST_QOUT && (!res.valid || res.ready)) begin
      res.hit_total <= total;
    end
  end

  always_comb begin
    state_next = state;
    cnt_next = cnt;
    req.ready = 1'b0;
    ram_we = 1'b0;
    ram_waddr = cnt;
    ram_wdata = '0;
    ram_raddr = cnt;
    unique case (state)
      ST_CLEAR: begin
        ram_we = 1'b1;
        cnt_next = cnt + 1'b1;
        if (cnt == LAST_IDX) begin
          cnt_next = '0;
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        req.ready = 1'b1;
        if (req.valid) begin
          cnt_next = '0;
          state_next = (req.req_type == REQ_QUERY) ? ST_QRUN : ST_MOD;
        end
      end
      ST_MOD: begin
        if (mod_done) begin
          state_next = ST_HRD;
        end
      end
      ST_HRD: begin
        ram_raddr = mod_rem;
        state_next = ST_HWR;
      end
      ST_HWR: begin
        ram_we = 1'b1;
        ram_waddr = mod_rem;
        ram_wdata = {req_time, hit_count};
        state_next = ST_IDLE;
      end
      ST_QRUN: begin
        cnt_next = cnt + 1'b1;
        if (cnt == LAST_IDX) begin
          cnt_next = '0;
          state_next = ST_QLAST;
        end
      end
      ST_QLAST: begin
        state_next = ST_QOUT;
      end
      ST_QOUT: begin
        if (!res.valid || res.ready) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

`ifndef SYNTHESIS
  assert property (@(posedge clk) disable iff (rst) mod_done |-> state == ST_MOD)
    else $error("Modulo result arrived outside of a hit request.");

  assert property (@(posedge clk) disable iff (rst)
    (state == ST_QRUN || state == ST_QLAST) |-> !ram_we)
    else $error("Bucket store written during a query walk.");

  assert property (@(posedge clk) disable iff (rst) $rose(res.valid) |-> $past(state) == ST_QOUT)
    else $error("Result presented without a finished query.");

  assert property (@(posedge clk) disable iff (rst) ram_we |-> ram_waddr <= LAST_IDX)
    else $error("Bucket write beyond the window.");

  assert property (@(posedge clk) disable iff (rst)
    (accept && req.req_type == REQ_HIT) |=> state == ST_MOD)
    else $error("Hit request did not start the modulo unit.");
`endif

endmodule
`default_nettype wire

// ===== bench/sliding_window_hit_counter_tb.sv =====
// Self-checking testbench for the sliding window hit counter with randomized request traffic.
module sliding_window_hit_counter_tb;
  import swhc_pkg::*;

  localparam int IDLE_MAX = 19;
  localparam int ITEM_TARGET = 1100;
  localparam int DRAIN_CYCLES = 400;
  localparam int STALL_LIMIT = 4000;

  typedef struct {
    logic req_type;
    logic [STAMP_W-1:0] timestamp;
    int unsigned gap;
  } hit_req_t;

  logic clk;
  logic rst;

  swhc_req_if req_ch();
  swhc_res_if res_ch();

  sliding_window_hit_counter u_dut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .res(res_ch)
  );

  hit_req_t pending_reqs[$];
  logic [TOTAL_W-1:0] expected_totals[$];
  logic [STAMP_W-1:0] sec_stamp [WINDOW_SECONDS];
  logic [COUNT_W-1:0] sec_count [WINDOW_SECONDS];
  int unsigned gap_left;
  int unsigned stall_left;
  int unsigned idle_cycles;
  int unsigned mismatches;
  bit burst_mode;
  bit rx_burst;

  function automatic void log_hit(logic [STAMP_W-1:0] t);
    int unsigned slot;
    slot = t % WINDOW_SECONDS;
    if (sec_stamp[slot] != t) begin
      sec_stamp[slot] = t;
      sec_count[slot] = 1;
    end else if (sec_count[slot] != COUNT_MAX) begin
      sec_count[slot] = sec_count[slot] + 1;
    end
  endfunction

  function automatic logic [TOTAL_W-1:0] tally_window(logic [STAMP_W-1:0] t);
    logic [TOTAL_W:0] acc;
    longint age;
    acc = '0;
    for (int i = 0; i < WINDOW_SECONDS; i++) begin
      age = longint'(t) - longint'(sec_stamp[i]);
      if (age < WINDOW_SECONDS) begin
        acc = acc + (TOTAL_W + 1)'(sec_count[i]);
        if (acc > {1'b0, TOTAL_MAX}) begin
          acc = {1'b0, TOTAL_MAX};
        end
      end
    end
    return acc[TOTAL_W-1:0];
  endfunction

  function automatic void add_req(logic kind, logic [STAMP_W-1:0] t);
    hit_req_t item;
    item.req_type = kind;
    item.timestamp = t;
    item.gap = burst_mode ? 0 : $urandom_range(0, IDLE_MAX);
    pending_reqs = {pending_reqs, item};
  endfunction

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    int unsigned run_len;
    int unsigned roll;
    logic [STAMP_W-1:0] now;
    rst = 1'b1;
    req_ch.valid = 1'b0;
    req_ch.req_type = REQ_HIT;
    req_ch.timestamp = '0;
    res_ch.ready = 1'b0;
    for (int i = 0; i < WINDOW_SECONDS; i++) begin
      sec_stamp[i] = '0;
      sec_count[i] = '0;
    end

    // A first hit at time zero matches the cleared stamp of its bucket.
    burst_mode = 1'b0;
    add_req(REQ_HIT, STAMP_W'(0));
    add_req(REQ_QUERY, STAMP_W'(1));
    add_req(REQ_HIT, STAMP_W'(1));
    add_req(REQ_HIT, STAMP_W'(1));
    add_req(REQ_HIT, STAMP_W'(1));
    add_req(REQ_HIT, STAMP_W'(299));
    add_req(REQ_HIT, STAMP_W'(300));
    add_req(REQ_QUERY, STAMP_W'(300));
    add_req(REQ_QUERY, STAMP_W'(599));
    add_req(REQ_QUERY, STAMP_W'(600));
    add_req(REQ_HIT, 31'h7FFFFFFF);
    add_req(REQ_HIT, 31'h7FFFFFFF);
    add_req(REQ_QUERY, 31'h7FFFFFFF);
    // Time going backwards: later stamps are still counted, older hits restamp.
    add_req(REQ_QUERY, STAMP_W'(5));
    add_req(REQ_HIT, STAMP_W'(247));
    add_req(REQ_QUERY, STAMP_W'(1000));
    add_req(REQ_HIT, 31'h2AAAAAAA);
    add_req(REQ_HIT, 31'h55555555);
    add_req(REQ_QUERY, 31'h55555555);
    add_req(REQ_QUERY, 31'h2AAAAAAA);

    while (pending_reqs.size() < ITEM_TARGET) begin
      burst_mode = ($urandom_range(0, 4) == 0);
      roll = $urandom_range(0, 99);
      if (roll < 85) begin
        if ($urandom_range(0, 3) == 0) begin
          now = STAMP_W'($urandom_range(1, 2000));
        end else begin
          now = STAMP_W'($urandom);
        end
        run_len = $urandom_range(20, 60);
        repeat (run_len) begin
          roll = $urandom_range(0, 99);
          if (roll < 60) begin
            now = now + STAMP_W'($urandom_range(0, 2));
          end else if (roll < 90) begin
            now = now + STAMP_W'($urandom_range(0, WINDOW_SECONDS));
          end else begin
            now = now + STAMP_W'($urandom_range(WINDOW_SECONDS, 3 * WINDOW_SECONDS));
          end
          add_req(($urandom_range(0, 3) == 0) ? REQ_QUERY : REQ_HIT, now);
        end
      end else begin
        repeat ($urandom_range(1, 5)) begin
          add_req(($urandom_range(0, 1) == 0) ? REQ_QUERY : REQ_HIT, STAMP_W'($urandom));
        end
      end
    end

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    do @(posedge clk);
    while (pending_reqs.size() != 0 || req_ch.valid || expected_totals.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_totals.size() != 0) begin
      $error("hit_total: %0d results never arrived", expected_totals.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  always @(posedge clk) begin
    hit_req_t nxt;
    if (rst) begin
      req_ch.valid <= 1'b0;
      gap_left = 0;
    end else begin
      if (req_ch.valid && req_ch.ready) begin
        if (req_ch.req_type == REQ_QUERY) begin
          expected_totals = {expected_totals, tally_window(req_ch.timestamp)};
        end else begin
          log_hit(req_ch.timestamp);
        end
      end
      if (!req_ch.valid || req_ch.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          req_ch.valid <= 1'b0;
        end else if (pending_reqs.size() != 0) begin
          nxt = pending_reqs.pop_front();
          req_ch.valid <= 1'b1;
          req_ch.req_type <= nxt.req_type;
          req_ch.timestamp <= nxt.timestamp;
          gap_left = (pending_reqs.size() != 0) ? pending_reqs[0].gap : 0;
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    logic [TOTAL_W-1:0] want_total;
    if (rst) begin
      res_ch.ready <= 1'b0;
      stall_left = $urandom_range(0, IDLE_MAX);
      rx_burst = 1'b0;
    end else begin
      if (res_ch.valid && res_ch.ready) begin
        if (expected_totals.size() == 0) begin
          $error("hit_total: expected no result, got %0d", res_ch.hit_total);
          mismatches++;
        end else begin
          want_total = expected_totals.pop_front();
          if (res_ch.hit_total !== want_total) begin
            $error("hit_total: expected %0d, got %0d", want_total, res_ch.hit_total);
            mismatches++;
          end
        end
        if ($urandom_range(0, 9) == 0) begin
          rx_burst = !rx_burst;
        end
        stall_left = rx_burst ? 0 : $urandom_range(0, IDLE_MAX);
      end else if (res_ch.valid && stall_left > 0) begin
        stall_left--;
      end
      res_ch.ready <= (stall_left == 0);
    end
  end

  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

endmodule
